// File: rtl/core/uartrxt_pkg.sv
// shared types, register indexes and constants of the uart receiver with timeouts
package uartrxt_pkg;

    localparam int unsigned CFG_W       = 16;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned DATA_W      = 8;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned BIT_IDX_W   = 4;
    localparam int unsigned DATA_BITS_DEF = 8;
    // bit positions at or above this index are sampled but not stored
    localparam int unsigned STORE_MAX   = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TIMEOUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TIMEOUT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSE_INVERTED = 3'd4;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] RST_BIT_PERIOD    = 16'd16;
    localparam logic [CFG_W-1:0] RST_START_OFFSET  = 16'd8;
    localparam logic [CFG_W-1:0] RST_START_TIMEOUT = 16'd250;
    localparam logic [CFG_W-1:0] RST_STOP_TIMEOUT  = 16'd100;
    localparam logic             RST_SENSE_INV     = 1'b1;

    typedef enum logic [1:0] {
        PH_WAIT_START = 2'd0,
        PH_OFFSET     = 2'd1,
        PH_DATA       = 2'd2,
        PH_STOP       = 2'd3
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_BYTE          = 2'd0,
        ST_START_TIMEOUT = 2'd1,
        ST_STOP_TIMEOUT  = 2'd2
    } t_status;

    typedef struct packed {
        logic [CFG_W-1:0] bit_period;
        logic [CFG_W-1:0] start_offset;
        logic [CFG_W-1:0] start_timeout;
        logic [CFG_W-1:0] stop_timeout;
        logic             sense_inverted;
    } t_cfg;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        t_status           status;
    } t_result;

endpackage

// File: rtl/core/uartrxt_ctrl.sv
// receive state machine: start detection, bit timing, data shift and timeouts
module uartrxt_ctrl #(
    parameter int unsigned DATA_BITS = uartrxt_pkg::DATA_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_line_sense,
    input  uartrxt_pkg::t_cfg    i_cfg,
    output logic                 o_res_valid,
    output uartrxt_pkg::t_result o_res
);
    import uartrxt_pkg::*;

    localparam int unsigned SHIFT_W = (DATA_BITS < STORE_MAX) ? DATA_BITS : STORE_MAX;
    localparam logic [BIT_IDX_W-1:0] LAST_IDX  = BIT_IDX_W'(DATA_BITS);
    localparam logic [BIT_IDX_W-1:0] STORE_LIM = BIT_IDX_W'(STORE_MAX);

    t_phase               r_phase, n_phase;
    logic [CFG_W-1:0]     r_tick, n_tick;
    logic [CFG_W-1:0]     r_wait, n_wait;
    logic [BIT_IDX_W-1:0] r_bit_idx, n_bit_idx;
    logic [SHIFT_W-1:0]   r_shift, n_shift;

    logic                 w_level;
    logic [CFG_W:0]       w_tick_inc;
    logic [CFG_W:0]       w_wait_inc;
    logic [BIT_IDX_W-1:0] w_bit_inc;
    logic                 w_period_done;
    logic                 w_offset_done;
    logic                 w_start_to;
    logic                 w_stop_to;
    logic                 w_res_valid;

    // level 1 is mark, level 0 is space
    assign w_level       = i_line_sense ^ i_cfg.sense_inverted;
    assign w_tick_inc    = {1'b0, r_tick} + 17'd1;
    assign w_wait_inc    = {1'b0, r_wait} + 17'd1;
    assign w_bit_inc     = r_bit_idx + 4'd1;
    assign w_period_done = !(w_tick_inc < {1'b0, i_cfg.bit_period});
    assign w_offset_done = w_tick_inc >= {1'b0, i_cfg.start_offset};
    assign w_start_to    = w_wait_inc > {1'b0, i_cfg.start_timeout};
    assign w_stop_to     = w_wait_inc > {1'b0, i_cfg.stop_timeout};

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_WAIT_START: begin
                if (!w_level) begin
                    n_phase = (i_cfg.start_offset == '0) ? PH_DATA : PH_OFFSET;
                end
            end
            PH_OFFSET: begin
                if (w_offset_done) begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (w_period_done && (w_bit_inc >= LAST_IDX)) begin
                    n_phase = PH_STOP;
                end
            end
            PH_STOP: begin
                if (w_level || w_stop_to) begin
                    n_phase = PH_WAIT_START;
                end
            end
            default: n_phase = PH_WAIT_START;
        endcase
    end

    // counters, shift register and result
    always_comb begin
        n_tick      = r_tick;
        n_wait      = r_wait;
        n_bit_idx   = r_bit_idx;
        n_shift     = r_shift;
        w_res_valid = 1'b0;
        o_res       = '{data: '0, status: ST_BYTE};
        unique case (r_phase)
            PH_WAIT_START: begin
                if (!w_level) begin
                    n_tick    = '0;
                    n_wait    = '0;
                    n_bit_idx = '0;
                    n_shift   = '0;
                end else if (w_start_to) begin
                    n_wait       = '0;
                    w_res_valid  = 1'b1;
                    o_res.status = ST_START_TIMEOUT;
                end else begin
                    n_wait = w_wait_inc[CFG_W-1:0];
                end
            end
            PH_OFFSET: begin
                n_tick = w_offset_done ? '0 : w_tick_inc[CFG_W-1:0];
            end
            PH_DATA: begin
                if (!w_period_done) begin
                    n_tick = w_tick_inc[CFG_W-1:0];
                end else begin
                    n_tick = '0;
                    if (r_bit_idx < STORE_LIM) begin
                        n_shift = {w_level, r_shift[SHIFT_W-1:1]};
                    end
                    if (w_bit_inc >= LAST_IDX) begin
                        n_bit_idx = '0;
                        n_wait    = '0;
                    end else begin
                        n_bit_idx = w_bit_inc;
                    end
                end
            end
            PH_STOP: begin
                if (w_level) begin
                    n_wait      = '0;
                    w_res_valid = 1'b1;
                    o_res.data  = DATA_W'(r_shift);
                end else if (w_stop_to) begin
                    n_wait       = '0;
                    w_res_valid  = 1'b1;
                    o_res.status = ST_STOP_TIMEOUT;
                end else begin
                    n_wait = w_wait_inc[CFG_W-1:0];
                end
            end
            default: n_wait = r_wait;
        endcase
    end

    assign o_res_valid = i_step && w_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_WAIT_START;
            r_tick    <= '0;
            r_wait    <= '0;
            r_bit_idx <= '0;
            r_shift   <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_wait    <= n_wait;
            r_bit_idx <= n_bit_idx;
            r_shift   <= n_shift;
        end
    end

    a_bit_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_idx < LAST_IDX)
        else $error("bit index beyond data bit count");

    a_bit_idx_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bit_idx != '0) |-> (r_phase == PH_DATA))
        else $error("bit index running outside data phase");

    a_byte_from_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status == ST_BYTE)) |-> (r_phase == PH_STOP))
        else $error("byte emitted outside stop phase");

endmodule

// File: rtl/core/uart_receiver_with_timeouts_core.sv
// top level of the uart receiver with start and stop timeouts
//
// one line sample (i_line_sense) is taken per accepted word, one word per clock when
// the result side keeps up. a start bit is a space level; after it the receiver waits
// start_offset ticks, then samples DATA_BITS data bits lsb first, one every bit_period
// ticks (zero acts as one), then waits for the mark level of the stop bit. each word
// yields at most one result: a byte (status 0), a start timeout (status 1) when the
// idle count passes start_timeout, or a stop timeout (status 2) when the wait for the
// stop level passes stop_timeout. sense_inverted (reset 1) flips the line polarity.
// a word waits in the input register until the state machine steps on it; the state
// machine and the result register update on that step. the result register has a
// skid entry behind it, so samples keep flowing while a result waits; o_stall only
// rises when both the result and the skid entry are full and a sample is pending.
// configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must
// write it only while the receiver is idle, which the block itself does not enforce;
// writes to indexes beyond the register list are ignored
module uart_receiver_with_timeouts_core #(
    parameter int unsigned DATA_BITS = uartrxt_pkg::DATA_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [uartrxt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [uartrxt_pkg::CFG_W-1:0]    i_cfg_data,
    // sample words in
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_line_sense,
    // result words out
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [uartrxt_pkg::DATA_W-1:0]   o_rx_data,
    output logic [uartrxt_pkg::STATUS_W-1:0] o_rx_status
);
    import uartrxt_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    logic    r_in_sense;
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    logic    w_step;
    logic    w_pop;
    logic    w_res_valid;
    t_result w_res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_period     <= RST_BIT_PERIOD;
            r_cfg.start_offset   <= RST_START_OFFSET;
            r_cfg.start_timeout  <= RST_START_TIMEOUT;
            r_cfg.stop_timeout   <= RST_STOP_TIMEOUT;
            r_cfg.sense_inverted <= RST_SENSE_INV;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BIT_PERIOD:     r_cfg.bit_period     <= i_cfg_data;
                CFG_START_OFFSET:   r_cfg.start_offset   <= i_cfg_data;
                CFG_START_TIMEOUT:  r_cfg.start_timeout  <= i_cfg_data;
                CFG_STOP_TIMEOUT:   r_cfg.stop_timeout   <= i_cfg_data;
                CFG_SENSE_INVERTED: r_cfg.sense_inverted <= i_cfg_data[0];
                default:            r_cfg.bit_period     <= r_cfg.bit_period;
            endcase
        end
    end

    // the pending sample moves on whenever the skid entry is free, so a result
    // always has a slot to land in
    assign w_step  = r_in_valid && !r_skid_valid;
    assign o_stall = r_in_valid && r_skid_valid;
    assign w_pop   = r_out_valid && !i_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (i_valid && !o_stall) begin
            r_in_sense <= i_line_sense;
        end
    end

    uartrxt_ctrl #(
        .DATA_BITS (DATA_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_line_sense (r_in_sense),
        .i_cfg        (r_cfg),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res)
    );

    // result register with skid entry; a new result never arrives while the skid is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else if (w_res_valid) begin
                r_out <= w_res;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (w_res_valid) begin
            if (!r_out_valid) begin
                r_out_valid <= 1'b1;
                r_out       <= w_res;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid       <= w_res;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_rx_data   = r_out.data;
    assign o_rx_status = r_out.status;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry full with empty result register");

    a_no_result_into_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !w_res_valid)
        else $error("result produced with no free slot");

    a_skid_moves_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && w_pop) |=> (r_out_valid && (r_out == $past(r_skid))))
        else $error("skid entry lost on pop");

endmodule

// File: dv/uart_receiver_with_timeouts_core_tb.sv
// self-checking testbench of the uart receiver with start and stop timeouts
module uart_receiver_with_timeouts_core_tb;

    import uartrxt_pkg::*;

    localparam int RESET_CYCLES   = 11;
    localparam int RX_BITS        = DATA_BITS_DEF;
    localparam int ITEM_TARGET    = 1550;
    localparam int DRAIN_CYCLES   = 8;      // two register stages plus the skid entry
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 150;
    localparam int PRINT_LIMIT    = 40;
    localparam int DIRECTED_N     = 25;

    // line levels after polarity correction
    localparam logic MARK  = 1'b1;
    localparam logic SPACE = 1'b0;

    localparam t_result NO_WORD = '{data: '0, status: ST_BYTE};

    localparam t_cfg RESET_SETTINGS = '{
        bit_period:     RST_BIT_PERIOD,
        start_offset:   RST_START_OFFSET,
        start_timeout:  RST_START_TIMEOUT,
        stop_timeout:   RST_STOP_TIMEOUT,
        sense_inverted: RST_SENSE_INV
    };

    // one tick per data bit, no offset, short timeouts, straight polarity
    localparam t_cfg DIRECTED_SETTINGS = '{
        bit_period:     16'd1,
        start_offset:   16'd0,
        start_timeout:  16'd3,
        stop_timeout:   16'd1,
        sense_inverted: 1'b0
    };

    typedef struct packed {
        logic    sense;
        logic    typed;     // expected word written into the row
        t_result want;
    } t_stim_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_line_sense;
    logic                 o_valid;
    logic                 i_stall;
    logic [DATA_W-1:0]    o_rx_data;
    logic [STATUS_W-1:0]  o_rx_status;

    // receiver mirror: settings and state
    t_cfg                 rx_cfg;
    t_phase               rx_phase;
    logic [CFG_W-1:0]     rx_ticks;
    logic [BIT_IDX_W-1:0] rx_bit;
    logic [DATA_W-1:0]    rx_shift;
    logic [CFG_W-1:0]     rx_wait;

    t_result rx_words_due[$];
    t_result oldest_word;
    t_stim_row directed_rows [DIRECTED_N];

    int  err_count      = 0;
    int  sent_count     = 0;
    int  settings_used  = 1;
    int  n_bytes        = 0;
    int  n_start_to     = 0;
    int  n_stop_to      = 0;
    int  quiet_cycles   = 0;
    int  stall_left     = 0;
    int  hold_left      = 0;
    int  hold_req       = 0;
    bit  calm           = 1'b0;

    uart_receiver_with_timeouts_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_line_sense (i_line_sense),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_rx_data    (o_rx_data),
        .o_rx_status  (o_rx_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one, none in a calm phase
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one line tick through the receiver mirror, returns 1 when a word comes out
    function automatic bit predict_line_tick(input logic sense, output t_result res);
        logic        lvl;
        logic [16:0] nxt;
        lvl = sense ^ rx_cfg.sense_inverted;
        res = NO_WORD;
        case (rx_phase)
            PH_WAIT_START: begin
                if (lvl == SPACE) begin
                    rx_wait  = '0;
                    rx_ticks = '0;
                    rx_bit   = '0;
                    rx_shift = '0;
                    rx_phase = (rx_cfg.start_offset == 0) ? PH_DATA : PH_OFFSET;
                    return 1'b0;
                end
                nxt = {1'b0, rx_wait} + 17'd1;
                if (nxt > {1'b0, rx_cfg.start_timeout}) begin
                    rx_wait    = '0;
                    res.status = ST_START_TIMEOUT;
                    return 1'b1;
                end
                rx_wait = nxt[CFG_W-1:0];
                return 1'b0;
            end
            PH_OFFSET: begin
                nxt = {1'b0, rx_ticks} + 17'd1;
                if (nxt >= {1'b0, rx_cfg.start_offset}) begin
                    rx_ticks = '0;
                    rx_phase = PH_DATA;
                end else begin
                    rx_ticks = nxt[CFG_W-1:0];
                end
                return 1'b0;
            end
            PH_DATA: begin
                // a zero period falls through here on every tick, as a period of one
                nxt = {1'b0, rx_ticks} + 17'd1;
                if (nxt < {1'b0, rx_cfg.bit_period}) begin
                    rx_ticks = nxt[CFG_W-1:0];
                    return 1'b0;
                end
                rx_ticks = '0;
                // lsb first; assumes at least eight data bits
                if (rx_bit < STORE_MAX) rx_shift = {lvl, rx_shift[DATA_W-1:1]};
                rx_bit = rx_bit + 1'b1;
                if (rx_bit >= RX_BITS) begin
                    rx_bit   = '0;
                    rx_wait  = '0;
                    rx_phase = PH_STOP;
                end
                return 1'b0;
            end
            default: begin
                if (lvl == MARK) begin
                    rx_phase = PH_WAIT_START;
                    rx_wait  = '0;
                    res.data = rx_shift;
                    return 1'b1;
                end
                nxt = {1'b0, rx_wait} + 17'd1;
                if (nxt > {1'b0, rx_cfg.stop_timeout}) begin
                    rx_phase   = PH_WAIT_START;
                    rx_wait    = '0;
                    res.status = ST_STOP_TIMEOUT;
                    return 1'b1;
                end
                rx_wait = nxt[CFG_W-1:0];
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        if (err_count < PRINT_LIMIT) $display("mismatch at %0t: %s", $time, what);
        err_count++;
    endtask

    // present one sample word; returns at the edge that takes it
    task automatic offer_word(input logic sense);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_line_sense <= sense;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic feed_sense(input logic sense);
        t_result res;
        offer_word(sense);
        sent_count++;
        if (predict_line_tick(sense, res)) rx_words_due.push_back(res);
    endtask

    task automatic feed_level(input logic lvl);
        feed_sense(lvl ^ rx_cfg.sense_inverted);
    endtask

    // idle mark, start bit, data bits with jitter between sampling ticks, stop level;
    // a broken frame is cut off somewhere after its start bit
    task automatic send_frame(input logic [DATA_W-1:0] byte_val, input bit broken);
        int  step, off, span, cut, lim, pre, spaces, t, k;
        logic lvl;
        step = (rx_cfg.bit_period == 0) ? 1 : int'(rx_cfg.bit_period);
        off  = int'(rx_cfg.start_offset);
        span = off + RX_BITS * step;
        cut  = broken ? $urandom_range(0, span) : span;
        lim  = (rx_cfg.start_timeout < 30) ? int'(rx_cfg.start_timeout) + 3 : 4;
        pre  = $urandom_range(0, 1) ? $urandom_range(0, lim) : $urandom_range(0, 2);
        repeat (pre) feed_level(MARK);
        feed_level(SPACE);
        for (t = 1; t <= cut; t++) begin
            lvl = SPACE;
            if (t > off) begin
                k   = (t - off - 1) / step;
                lvl = (k < DATA_W) ? byte_val[k] : MARK;
            end
            if ((t <= off || (t - off) % step != 0) && $urandom_range(0, 7) == 0)
                lvl = ~lvl;
            feed_level(lvl);
        end
        if (!broken) begin
            lim    = (rx_cfg.stop_timeout < 6) ? int'(rx_cfg.stop_timeout) + 2 : 8;
            spaces = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, lim);
            repeat (spaces) feed_level(SPACE);
            feed_level(MARK);
        end
    endtask

    // let every expected word arrive, then the pipeline run dry
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (rx_words_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // called on a falling edge; keeps the write enable high across the writes
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input t_cfg c);
        set_reg(CFG_BIT_PERIOD, c.bit_period);
        set_reg(CFG_START_OFFSET, c.start_offset);
        set_reg(CFG_START_TIMEOUT, c.start_timeout);
        set_reg(CFG_STOP_TIMEOUT, c.stop_timeout);
        set_reg(CFG_SENSE_INVERTED, CFG_W'(c.sense_inverted));
        // an index past the register list must change nothing
        if ($urandom_range(0, 2) == 0)
            set_reg(CFG_IDX_W'($urandom_range(int'(CFG_SENSE_INVERTED) + 1,
                                              (1 << CFG_IDX_W) - 1)),
                    CFG_W'($urandom()));
        i_cfg_we <= 1'b0;
        rx_cfg = c;
        settings_used++;
    endtask

    function automatic t_cfg draw_settings();
        t_cfg c;
        int   r;
        r = $urandom_range(0, 9);
        c.bit_period   = (r == 0) ? '0 : CFG_W'($urandom_range(1, 4));
        c.start_offset = CFG_W'($urandom_range(0, 5));
        r = $urandom_range(0, 3);
        c.start_timeout = (r == 0) ? '0 : (r == 3) ? '1 : CFG_W'($urandom_range(2, 30));
        r = $urandom_range(0, 3);
        c.stop_timeout  = (r == 0) ? '0 : (r == 3) ? '1 : CFG_W'($urandom_range(1, 6));
        c.sense_inverted = 1'($urandom_range(0, 1));
        return c;
    endfunction

    task automatic run_phase(input t_cfg c, input int items, input int hold);
        int stop_at;
        apply_settings(c);
        calm = ($urandom_range(0, 3) == 0);
        if (hold > 0) hold_req = hold;
        stop_at = sent_count + items;
        while (sent_count < stop_at) begin
            // huge periods would take too long for whole frames
            if (c.bit_period > 64 || c.start_offset > 64) begin
                feed_sense(1'($urandom_range(0, 1)));
            end else begin
                case ($urandom_range(0, 9))
                    0: repeat ($urandom_range(1, 10)) feed_sense(1'($urandom_range(0, 1)));
                    1: send_frame(DATA_W'($urandom()), 1'b1);
                    default: send_frame(DATA_W'($urandom()), 1'b0);
                endcase
            end
        end
        settle();
    endtask

    // result side: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
            stall_left = pick_gap();
        end
    end

    // compare each taken result word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            case (o_rx_status)
                ST_BYTE:          n_bytes++;
                ST_START_TIMEOUT: n_start_to++;
                default:          n_stop_to++;
            endcase
            if (rx_words_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word, data %02h status %0d",
                                          o_rx_data, o_rx_status));
            end else begin
                oldest_word = rx_words_due.pop_front();
                if (o_rx_data !== oldest_word.data)
                    report_mismatch($sformatf("data %02h, expected %02h",
                                              o_rx_data, oldest_word.data));
                if (o_rx_status !== oldest_word.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_rx_status, oldest_word.status));
            end
        end
    end

    // ends the run when neither side moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int      n;
        bit      has;
        t_result res;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_line_sense = 1'b0;
        i_stall      = 1'b0;

        rx_cfg   = RESET_SETTINGS;
        rx_phase = PH_WAIT_START;
        rx_ticks = '0;
        rx_bit   = '0;
        rx_shift = '0;
        rx_wait  = '0;

        // sense inverted off in the directed rows, so sense equals line level:
        // idle up to a start timeout, an all-ones byte, an all-zeros byte whose
        // stop bit never comes
        for (n = 0; n < 3; n++) directed_rows[n] = '{MARK, 1'b0, NO_WORD};
        directed_rows[3] = '{MARK, 1'b1, '{data: 8'h00, status: ST_START_TIMEOUT}};
        directed_rows[4] = '{SPACE, 1'b0, NO_WORD};
        for (n = 5; n < 13; n++) directed_rows[n] = '{MARK, 1'b0, NO_WORD};
        directed_rows[13] = '{MARK, 1'b1, '{data: 8'hFF, status: ST_BYTE}};
        directed_rows[14] = '{SPACE, 1'b0, NO_WORD};
        for (n = 15; n < 24; n++) directed_rows[n] = '{SPACE, 1'b0, NO_WORD};
        directed_rows[24] = '{SPACE, 1'b1, '{data: 8'h00, status: ST_STOP_TIMEOUT}};

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // untouched reset settings; whole frames leave the receiver waiting for a start
        repeat (2) send_frame(DATA_W'($urandom()), 1'b0);
        settle();

        apply_settings(DIRECTED_SETTINGS);
        for (n = 0; n < DIRECTED_N; n++) begin
            offer_word(directed_rows[n].sense);
            sent_count++;
            has = predict_line_tick(directed_rows[n].sense, res);
            if (directed_rows[n].typed) rx_words_due.push_back(directed_rows[n].want);
            else if (has) rx_words_due.push_back(res);
        end
        settle();

        // every register at its top value, a few ticks only
        run_phase('{bit_period: '1, start_offset: '1, start_timeout: '1,
                    stop_timeout: '1, sense_inverted: 1'b1}, 40, 0);
        // zero period and timeouts: a word per idle tick while the result side
        // holds off, so the skid fills and the input stalls
        run_phase('{bit_period: '0, start_offset: '0, start_timeout: '0,
                    stop_timeout: '0, sense_inverted: 1'b0}, 90, HOLD_CYCLES);

        while (sent_count < ITEM_TARGET)
            run_phase(draw_settings(), $urandom_range(120, 200), 0);

        $display("ran %0d line samples under %0d register settings", sent_count,
                 settings_used);
        $display("seen %0d bytes, %0d start timeouts, %0d stop timeouts", n_bytes,
                 n_start_to, n_stop_to);
        if (err_count == 0 && rx_words_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: uart_receiver_with_timeouts_core.f
rtl/core/uartrxt_pkg.sv
rtl/core/uartrxt_ctrl.sv
rtl/core/uart_receiver_with_timeouts_core.sv
dv/uart_receiver_with_timeouts_core_tb.sv
